/* rtl/rccd_pkg.sv */
// shared types and constants for the rotary count chatter debounce block
package rccd_pkg;

  // raw and filtered direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } dir_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIRECTION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAME_DIR_HOLDOFF_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_HOLDOFF_MS  = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  // hold-off values after reset
  localparam logic [15:0] SAME_HOLDOFF_RESET    = 16'd50;
  localparam logic [15:0] REVERSE_HOLDOFF_RESET = 16'd500;

  typedef struct packed {
    logic        reverse_direction;
    logic [15:0] same_dir_holdoff_ms;
    logic [15:0] reverse_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] stable_value;
    logic signed [15:0] position;
    logic               changed;
    logic signed [7:0]  step;
  } result_t;

endpackage

/* rtl/rccd_filter.sv */
// per-poll count extension, chatter filter and hold-off debounce with its state
module rccd_filter
  import rccd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  enc_count,
  input  logic [31:0] now_ms,
  input  cfg_t        cfg,
  output result_t     res
);

  logic [7:0]  prev_raw;
  logic [15:0] extended_count;
  dir_t        confirmed_raw_dir;
  logic [1:0]  reverse_tally;
  dir_t        reverse_sign;
  logic [15:0] held_value;
  dir_t        held_dir;
  logic [31:0] held_time;

  logic [15:0] extended_count_next;
  dir_t        confirmed_raw_dir_next;
  logic [1:0]  reverse_tally_next;
  dir_t        reverse_sign_next;
  logic [15:0] held_value_next;
  dir_t        held_dir_next;
  logic [31:0] held_time_next;

  logic [7:0]  diff;
  logic [15:0] pos;
  logic [15:0] delta;
  logic [31:0] elapsed;
  logic [1:0]  tally_inc;
  dir_t        raw_dir;
  dir_t        cur_dir;
  logic        unit;
  logic        proceed;
  logic        accept;
  logic        chg;

  always_comb begin
    diff                = enc_count - prev_raw;
    extended_count_next = extended_count + {{8{diff[7]}}, diff};
    pos = cfg.reverse_direction ? 16'(16'd0 - extended_count_next) : extended_count_next;

    raw_dir   = diff[7] ? DIR_NEG : DIR_POS;
    unit      = (diff == 8'h01) || (diff == 8'hFF);
    tally_inc = reverse_tally + 2'd1;
    delta     = pos - held_value;
    cur_dir   = delta[15] ? DIR_NEG : DIR_POS;
    elapsed   = now_ms - held_time;

    confirmed_raw_dir_next = confirmed_raw_dir;
    reverse_tally_next     = reverse_tally;
    reverse_sign_next      = reverse_sign;
    held_value_next        = held_value;
    held_dir_next          = held_dir;
    held_time_next         = held_time;
    proceed                = 1'b0;
    accept                 = 1'b0;
    chg                    = 1'b0;

    if (diff != 8'd0) begin
      proceed = 1'b1;
      if (confirmed_raw_dir != DIR_NONE && raw_dir != confirmed_raw_dir && unit) begin
        if (reverse_sign == DIR_NONE || reverse_sign == raw_dir) begin
          // second opposite unit step in a row confirms the turn
          if (tally_inc >= 2'd2) begin
            confirmed_raw_dir_next = raw_dir;
            reverse_tally_next     = 2'd0;
            reverse_sign_next      = DIR_NONE;
          end else begin
            reverse_sign_next  = raw_dir;
            reverse_tally_next = tally_inc;
            proceed            = 1'b0;
          end
        end else begin
          reverse_sign_next  = raw_dir;
          reverse_tally_next = 2'd1;
          proceed            = 1'b0;
        end
      end else begin
        reverse_tally_next     = 2'd0;
        reverse_sign_next      = DIR_NONE;
        confirmed_raw_dir_next = raw_dir;
      end

      if (proceed && delta != 16'd0) begin
        if (held_dir == DIR_NONE) begin
          accept = 1'b1;
        end else if (cur_dir == held_dir) begin
          accept = elapsed >= {16'd0, cfg.same_dir_holdoff_ms};
        end else begin
          accept = elapsed >= {16'd0, cfg.reverse_holdoff_ms};
        end
        if (accept) begin
          held_value_next = pos;
          held_dir_next   = cur_dir;
          held_time_next  = now_ms;
          chg             = 1'b1;
        end
      end
    end

    res.stable_value = held_value_next;
    res.position     = pos;
    res.changed      = chg;
    res.step         = diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw          <= 8'd0;
      extended_count    <= 16'd0;
      confirmed_raw_dir <= DIR_NONE;
      reverse_tally     <= 2'd0;
      reverse_sign      <= DIR_NONE;
      held_value        <= 16'd0;
      held_dir          <= DIR_NONE;
      held_time         <= 32'd0;
    end else if (fire) begin
      prev_raw          <= enc_count;
      extended_count    <= extended_count_next;
      confirmed_raw_dir <= confirmed_raw_dir_next;
      reverse_tally     <= reverse_tally_next;
      reverse_sign      <= reverse_sign_next;
      held_value        <= held_value_next;
      held_dir          <= held_dir_next;
      held_time         <= held_time_next;
    end
  end

endmodule

/* rtl/rotary_count_chatter_debounce.sv */
// top level of the rotary count chatter debounce block
//
// usage:
// - input channel (in_valid/in_ready) carries one poll per item: the wrapping
//   8-bit encoder count enc_count and the millisecond timestamp now_ms
// - output channel (out_valid/out_ready) returns exactly one result item per
//   poll: stable_value, position, changed and step, in poll order
// - config channel (cfg_valid/cfg_ready) writes cfg_index 0 reverse_direction,
//   1 same-direction hold-off, 2 reversal hold-off; index 3 is ignored;
//   cfg_ready is always high, writes are meant to happen while the block idles
// - an accepted poll goes into the input register, then through the filter
//   logic into the result register, from which it can be taken
// - throughput: one poll per cycle while out_ready keeps the result register
//   free or draining, set by the single pass from the input register
//   through the filter state update into the result register
// - the poll state updates when the item moves to the result register, so
//   the next poll right behind it sees the updated count and hold-off state
// - when out_ready is low the result register holds, the input register can
//   still take one more poll, then in_ready drops until the output drains
// - reset (rst, synchronous) empties both registers, clears the count and
//   filter state and restores hold-offs of 50 ms and 500 ms
module rotary_count_chatter_debounce
  import rccd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            enc_count,
  input  logic [31:0]           now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    stable_value,
  output logic signed [15:0]    position,
  output logic                  changed,
  output logic signed [7:0]     step,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // input register
  logic        in_full;
  logic [7:0]  raw_q;
  logic [31:0] now_q;

  // result register
  logic        out_full;
  result_t     res_q;
  result_t     res_comb;

  cfg_t        cfg;
  logic        fire;

  // move a poll through the filter when the result slot is free or draining
  assign fire     = in_full && (!out_full || out_ready);
  assign in_ready = !in_full || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_q <= enc_count;
      now_q <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_comb;
    end
  end

  // configuration registers, out-of-range index does nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_direction   <= 1'b0;
      cfg.same_dir_holdoff_ms <= SAME_HOLDOFF_RESET;
      cfg.reverse_holdoff_ms  <= REVERSE_HOLDOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REVERSE_DIRECTION:   cfg.reverse_direction   <= cfg_data[0];
        CFG_SAME_DIR_HOLDOFF_MS: cfg.same_dir_holdoff_ms <= cfg_data;
        CFG_REVERSE_HOLDOFF_MS:  cfg.reverse_holdoff_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  rccd_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .enc_count (raw_q),
    .now_ms    (now_q),
    .cfg       (cfg),
    .res       (res_comb)
  );

  assign out_valid    = out_full;
  assign stable_value = res_q.stable_value;
  assign position     = res_q.position;
  assign changed      = res_q.changed;
  assign step         = res_q.step;

endmodule

/* rtl/rccd_checker.sv */
// port-level checks for the rotary count chatter debounce block, with bind
module rccd_checker
  import rccd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [15:0]    stable_value,
  input logic signed [15:0]    position,
  input logic                  changed,
  input logic signed [7:0]     step
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result keeps its values
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stable_value) && $stable(position)
      && $stable(changed) && $stable(step))
    else $error("stalled result changed");

  // an accepted change moves the debounced value onto the position
  a_change_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> stable_value == position)
    else $error("changed result with stable_value off position");

  // a poll with no count movement never changes the debounced value
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && step == 8'sd0 |-> !changed)
    else $error("change reported for zero step");

endmodule

bind rotary_count_chatter_debounce rccd_checker u_rccd_checker (.*);

/* bench/rotary_count_chatter_debounce_tb.sv */
// self-checking testbench for the rotary count chatter debounce block
module rotary_count_chatter_debounce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rccd_pkg::*;

  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

  typedef struct {
    logic [7:0]  raw;
    logic [31:0] ms;
  } poll_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            enc_count = '0;
  logic [31:0]           now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    stable_value;
  logic signed [15:0]    position;
  logic                  changed;
  logic signed [7:0]     step;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rotary_count_chatter_debounce DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .enc_count    (enc_count),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stable_value (stable_value),
    .position     (position),
    .changed      (changed),
    .step         (step),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // polls waiting for the driver, and the reports the block owes us
  poll_t   poll_q[$];
  result_t report_q[$];

  int      errors       = 0;
  int      results_seen = 0;
  int      queued       = 0;
  logic    poll_taken   = 1'b0;
  logic    idle_on      = 1'b0;
  logic    long_hold    = 1'b0;
  int      send_gap     = 0;
  int      sink_gap     = 0;

  // our copy of the configuration registers
  logic        neg_mode  = 1'b0;
  logic [15:0] same_hold = SAME_HOLDOFF_RESET;
  logic [15:0] rev_hold  = REVERSE_HOLDOFF_RESET;

  // our copy of the counting and filter state
  logic [7:0]  last_raw    = '0;
  logic [15:0] pos_count   = '0;
  dir_t        conf_dir    = DIR_NONE;
  logic [1:0]  rev_tally   = '0;
  dir_t        rev_sign    = DIR_NONE;
  logic [15:0] stable_hold = '0;
  dir_t        stable_dir  = DIR_NONE;
  logic [31:0] stable_ms   = '0;

  // stimulus cursor: the encoder count and clock we pretend to have
  logic [7:0]  knob_raw = '0;
  logic [31:0] clock_ms = '0;
  int          spin     = 1;

  // one poll through the count extension and the debounce filter
  task automatic debounce_poll(input logic [7:0] raw, input logic [31:0] now);
    logic [7:0]  diff;
    logic [15:0] pos;
    logic [15:0] delta;
    logic [31:0] elapsed;
    dir_t        raw_dir;
    dir_t        cur_dir;
    logic        unit_step;
    logic        proceed;
    logic        accept;
    logic        moved;
    result_t     r;
    diff      = raw - last_raw;
    moved     = 1'b0;
    last_raw  = raw;
    pos_count = pos_count + {{8{diff[7]}}, diff};
    pos       = neg_mode ? 16'd0 - pos_count : pos_count;
    if (diff != 8'd0) begin
      raw_dir   = diff[7] ? DIR_NEG : DIR_POS;
      unit_step = (diff == 8'h01) || (diff == 8'hff);
      proceed   = 1'b1;
      if (conf_dir != DIR_NONE && raw_dir != conf_dir && unit_step) begin
        // a unit step against the confirmed direction: chatter until seen twice
        if (rev_sign == DIR_NONE || rev_sign == raw_dir) begin
          rev_sign  = raw_dir;
          rev_tally = rev_tally + 2'd1;
          if (rev_tally >= 2'd2) begin
            conf_dir  = raw_dir;
            rev_tally = 2'd0;
            rev_sign  = DIR_NONE;
          end else begin
            proceed = 1'b0;
          end
        end else begin
          rev_sign  = raw_dir;
          rev_tally = 2'd1;
          proceed   = 1'b0;
        end
      end else begin
        rev_tally = 2'd0;
        rev_sign  = DIR_NONE;
        conf_dir  = raw_dir;
      end
      if (proceed) begin
        delta = pos - stable_hold;
        if (delta != 16'd0) begin
          cur_dir = delta[15] ? DIR_NEG : DIR_POS;
          elapsed = now - stable_ms;
          if (stable_dir == DIR_NONE) begin
            accept = 1'b1;
          end else if (cur_dir == stable_dir) begin
            accept = elapsed >= {16'd0, same_hold};
          end else begin
            accept = elapsed >= {16'd0, rev_hold};
          end
          if (accept) begin
            stable_hold = pos;
            stable_dir  = cur_dir;
            stable_ms   = now;
            moved       = 1'b1;
          end
        end
      end
    end
    r.stable_value = stable_hold;
    r.position     = pos;
    r.changed      = moved;
    r.step         = diff;
    report_q.push_back(r);
  endtask

  // sender: a new poll goes out only once the previous one was taken
  always @(negedge clk) begin : feed_polls
    poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || poll_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (poll_q.size() != 0) begin
        nxt = poll_q.pop_front();
        in_valid  <= 1'b1;
        enc_count <= nxt.raw;
        now_ms    <= nxt.ms;
        if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus the long hold from the pressure process
  always @(negedge clk) begin
    if (long_hold) begin
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 8);
    end
  end

  // predict on every accepted poll, check every accepted report
  always @(posedge clk) begin : check_reports
    result_t want;
    if (rst) begin
      poll_taken <= 1'b0;
    end else begin
      poll_taken <= in_valid && in_ready;
      if (in_valid && in_ready) debounce_poll(enc_count, now_ms);
      if (out_valid && out_ready) begin
        results_seen++;
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: report with nothing expected: stable %0d pos %0d chg %0b step %0d",
                   $time, stable_value, position, changed, step);
        end else begin
          want = report_q.pop_front();
          if (want.stable_value !== stable_value || want.position !== position ||
              want.changed !== changed || want.step !== step) begin
            errors++;
            $display({"%0t: mismatch expected stable %0d pos %0d chg %0b step %0d,",
                      " got stable %0d pos %0d chg %0b step %0d"},
                     $time, want.stable_value, want.position, want.changed, want.step,
                     stable_value, position, changed, step);
          end
        end
      end
    end
  end

  // back-pressure: the sink stops for a long while so the block fills and stalls input
  initial begin
    wait (results_seen >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (60) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic add_poll(input logic [7:0] raw, input logic [31:0] ms);
    poll_t p;
    p.raw = raw;
    p.ms  = ms;
    poll_q.push_back(p);
    queued++;
  endtask

  // move the knob by d counts after dt milliseconds
  task automatic turn(input int d, input int unsigned dt);
    knob_raw = knob_raw + d[7:0];
    clock_ms = clock_ms + dt;
    add_poll(knob_raw, clock_ms);
  endtask

  // time steps clustered around a hold-off so both sides of it get hit
  function automatic int unsigned pick_dt(input logic [15:0] hold);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 5);
      1: return (hold == 16'd0) ? $urandom_range(0, 1) : hold - 1 + $urandom_range(0, 2);
      2: return $urandom_range(0, 2 * hold + 2);
      default: return $urandom_range(0, 30);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REVERSE_DIRECTION:   neg_mode  = val[0];
      CFG_SAME_DIR_HOLDOFF_MS: same_hold = val;
      CFG_REVERSE_HOLDOFF_MS:  rev_hold  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed turning with chatter and reversals, some noise
  task automatic random_polls(input int n);
    int target;
    int kind;
    target = queued + n;
    while (queued < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        turn(spin * (($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : 1), pick_dt(same_hold));
      end else if (kind < 62) begin
        // lone backward step, then carry on
        turn(-spin, pick_dt(same_hold));
        turn(spin, pick_dt(same_hold));
      end else if (kind < 76) begin
        // real reversal: two backward unit steps in a row
        spin = -spin;
        turn(spin, pick_dt(rev_hold));
        turn(spin, pick_dt(rev_hold));
      end else if (kind < 82) begin
        turn(0, pick_dt(same_hold));
      end else if (kind < 94) begin
        knob_raw = 8'($urandom_range(0, 255));
        clock_ms = clock_ms + pick_dt(rev_hold);
        add_poll(knob_raw, clock_ms);
      end else begin
        clock_ms = $urandom();
        turn(spin, 0);
      end
    end
  endtask

  // wait until every poll went through and every report came back
  task automatic drain();
    do @(posedge clk); while (poll_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input logic idle);
    @(posedge clk);
    idle_on = idle;
    random_polls(n);
    drain();
  endtask

  initial begin
    logic [15:0] junk;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    // directed part with the reset hold-offs of 50 and 500 ms
    add_poll(8'd0, 32'd0);           // no movement at all
    turn(1, 10);                     // first change is taken whatever the time
    turn(1, 10);                     // too soon in the same direction
    turn(1, 40);                     // right at the same-direction hold-off
    turn(-1, 5);                     // lone backward step held as chatter
    turn(1, 5);                      // back in line, position equals stable value
    turn(-1, 100);                   // first backward step again
    turn(-1, 100);                   // second one confirms, reversal still too early
    turn(-1, 300);                   // now past the reversal hold-off
    turn(-1, 499);
    turn(127, 600);                  // largest forward step
    turn(-128, 600);                 // largest backward step
    turn(2, 1);                      // non-unit step against the confirmed direction
    add_poll(8'hff, clock_ms + 60);  // raw count wraps 255 -> 0
    add_poll(8'h00, clock_ms + 120);
    knob_raw = 8'h00;
    clock_ms = 32'hffff_fff0;        // millisecond clock wraps through zero
    turn(1, 0);
    turn(1, 100);
    turn(-1, 600);
    turn(-1, 600);
    drain();

    // reversed counting, hold-offs at zero: every change goes through
    write_reg(CFG_REVERSE_DIRECTION, 16'hffff);
    write_reg(CFG_SAME_DIR_HOLDOFF_MS, 16'd0);
    write_reg(CFG_REVERSE_HOLDOFF_MS, 16'd0);
    run_phase(250, 1'b1);

    // normal counting, hold-offs at their maximum
    junk = 16'($urandom());
    junk[0] = 1'b0;
    write_reg(CFG_REVERSE_DIRECTION, junk);
    write_reg(CFG_SAME_DIR_HOLDOFF_MS, 16'hffff);
    write_reg(CFG_REVERSE_HOLDOFF_MS, 16'hffff);
    run_phase(250, 1'b1);

    // mid-range settings, a write to the unused index, then a fast spin
    // far enough to wrap the 16-bit position
    write_reg(CFG_IDX_NONE, 16'($urandom()));
    write_reg(CFG_REVERSE_DIRECTION, 16'($urandom()));
    write_reg(CFG_SAME_DIR_HOLDOFF_MS, 16'($urandom_range(10, 80)));
    write_reg(CFG_REVERSE_HOLDOFF_MS, 16'($urandom_range(100, 700)));
    @(posedge clk);
    idle_on = 1'b0;
    repeat (330) turn(spin * $urandom_range(96, 127), $urandom_range(0, 60));
    drain();
    run_phase(150, 1'b1);

    // last stretch at full rate, no idling on either side
    write_reg(CFG_SAME_DIR_HOLDOFF_MS, SAME_HOLDOFF_RESET);
    write_reg(CFG_REVERSE_HOLDOFF_MS, REVERSE_HOLDOFF_RESET);
    run_phase(150, 1'b0);

    repeat (4) @(posedge clk);
    if (report_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
